FILE: sv/tvkt_pkg.sv
// ----------------------------------------------------------------------------
// tvkt_pkg: shared types and constants of the two-value key table
// Entry, request and response structs, operation and status codes, and the
// widths that follow from the table depth.
// ----------------------------------------------------------------------------
package tvkt_pkg;

  localparam int Depth     = 16;
  localparam int IdxW      = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW      = $clog2(Depth + 1);
  localparam int MaxPerKey = 2;
  localparam int HitW      = $clog2(MaxPerKey + 1);
  localparam int CapW      = 5;
  localparam int DataW     = 32;
  localparam int CapReset  = 16;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_SEARCH = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STAT_DONE = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2
  } status_e;

  typedef enum logic {
    REG_CAPACITY = 1'b0,
    REG_NULL     = 1'b1
  } reg_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FIND,
    S_FIX,
    S_RESP
  } state_e;

  typedef struct packed {
    logic signed [DataW-1:0] key;
    logic signed [DataW-1:0] value;
  } entry_t;

  typedef struct packed {
    logic [1:0]              kind;
    logic signed [DataW-1:0] key;
    logic signed [DataW-1:0] value;
  } tvkt_req_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [DataW-1:0] first_value;
    logic signed [DataW-1:0] second_value;
    logic [4:0]              pair_count;
    logic                    is_empty;
    logic                    is_full;
  } tvkt_rsp_t;

  // ring control from the sequencer to the cells
  typedef struct packed {
    logic   shift;
    logic   inject;
    entry_t entry;
  } ring_ctl_t;

endpackage

FILE: sv/tvkt_cell.sv
// ----------------------------------------------------------------------------
// tvkt_cell: one slot of the entry ring
// Holds one key/value pair; on shift it takes its neighbor's pair, or the
// injected pair when this slot is the insertion point.
// ----------------------------------------------------------------------------
module tvkt_cell
  import tvkt_pkg::*;
(
  input  logic      clk_i,
  input  ring_ctl_t ctl_i,
  input  entry_t    nbr_i,
  output entry_t    entry_o
);

  entry_t entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.shift) begin
      entry_d = ctl_i.inject ? ctl_i.entry : nbr_i;
    end
  end

  // payload only, contents undefined until written
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

FILE: sv/tvkt_ctrl.sv
// ----------------------------------------------------------------------------
// tvkt_ctrl: sequencer of the two-value key table
// Configuration registers, pair count, scan over the rotating entry ring,
// match counting and result formation.
// ----------------------------------------------------------------------------
module tvkt_ctrl
  import tvkt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  tvkt_req_t        req_i,
  output logic             done_o,
  output tvkt_rsp_t        rsp_o,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [DataW-1:0] cfg_wdata_i,
  input  entry_t           head_i,
  output ring_ctl_t        ring_o
);

  localparam logic [IdxW-1:0] LastIdx = IdxW'(Depth - 1);

  state_e                  state_q, state_d;
  logic [CapW-1:0]         cap_cfg_q;
  logic [DataW-1:0]        null_q;
  logic [CntW-1:0]         count_q, count_d;
  logic [CntW-1:0]         cap_q, cap_d;
  logic [IdxW-1:0]         idx_q, idx_d;
  logic [IdxW-1:0]         pos_q, pos_d;
  logic [HitW-1:0]         hits_q, hits_d;
  logic                    found_q, found_d;
  kind_e                   kind_q, kind_d;
  status_e                 status_q, status_d;
  logic signed [DataW-1:0] key_q, key_d, val_q, val_d;
  logic signed [DataW-1:0] first_q, first_d, second_q, second_d;
  entry_t                  last_q, last_d;
  logic [CntW-1:0]         idx_ext;
  logic                    in_range, key_hit, pair_hit;
  logic [CntW-1:0]         eff_cap;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_cfg_q <= CapW'(CapReset);
      null_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_idx_i))
        REG_CAPACITY: cap_cfg_q <= cfg_wdata_i[CapW-1:0];
        REG_NULL:     null_q    <= cfg_wdata_i;
        default:      ;
      endcase
    end
  end

  // zero counts as one, above the depth counts as the depth
  always_comb begin
    if (cap_cfg_q == '0) begin
      eff_cap = CntW'(1);
    end else if (32'(cap_cfg_q) > Depth) begin
      eff_cap = CntW'(Depth);
    end else begin
      eff_cap = CntW'(cap_cfg_q);
    end
  end

  assign idx_ext  = CntW'(idx_q);
  assign in_range = idx_ext < count_q;
  assign key_hit  = head_i.key == key_q;
  assign pair_hit = key_hit && (head_i.value == val_q);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    cap_d     = cap_q;
    idx_d     = idx_q;
    pos_d     = pos_q;
    hits_d    = hits_q;
    found_d   = found_q;
    kind_d    = kind_q;
    status_d  = status_q;
    key_d     = key_q;
    val_d     = val_q;
    first_d   = first_q;
    second_d  = second_q;
    last_d    = last_q;
    ring_o    = '{shift: 1'b0, inject: 1'b0, entry: '{key: key_q, value: val_q}};
    done_o    = 1'b0;
    busy      = state_q != S_IDLE;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          kind_d   = kind_e'(req_i.kind);
          key_d    = req_i.key;
          val_d    = req_i.value;
          cap_d    = eff_cap;
          first_d  = null_q;
          second_d = null_q;
          idx_d    = '0;
          hits_d   = '0;
          found_d  = 1'b0;
          if (kind_e'(req_i.kind) == KIND_NONE) begin
            status_d = STAT_MISS;
            state_d  = S_RESP;
          end else if (kind_e'(req_i.kind) == KIND_ADD && count_q >= eff_cap) begin
            // full test comes before the duplicate test
            status_d = STAT_FULL;
            state_d  = S_RESP;
          end else begin
            state_d = S_FIND;
          end
        end
      end

      S_FIND: begin
        // head cell holds entry idx_q of the table
        ring_o.shift = 1'b1;
        idx_d        = idx_q + IdxW'(1);
        case (kind_q)
          KIND_ADD: begin
            if (in_range && key_hit && hits_q < HitW'(MaxPerKey)) begin
              hits_d = hits_q + HitW'(1);
            end
            // append slot comes after every stored entry, count is final here
            if (idx_ext == count_q && hits_q < HitW'(MaxPerKey)) begin
              ring_o.inject = 1'b1;
            end
          end
          KIND_SEARCH: begin
            if (in_range && key_hit && hits_q < HitW'(MaxPerKey)) begin
              if (hits_q == '0) begin
                first_d = head_i.value;
              end else begin
                second_d = head_i.value;
              end
              hits_d = hits_q + HitW'(1);
            end
          end
          KIND_REMOVE: begin
            if (in_range && pair_hit && !found_q) begin
              found_d = 1'b1;
              pos_d   = idx_q;
            end
            if (in_range && idx_ext == count_q - CntW'(1)) begin
              last_d = head_i;
            end
          end
          default: ;
        endcase
        if (idx_q == LastIdx) begin
          idx_d = '0;
          case (kind_q)
            KIND_ADD: begin
              if (hits_q < HitW'(MaxPerKey)) begin
                status_d = STAT_DONE;
                count_d  = count_q + CntW'(1);
              end else begin
                status_d = STAT_MISS;
              end
              state_d = S_RESP;
            end
            KIND_REMOVE: begin
              if (found_d) begin
                state_d = S_FIX;
              end else begin
                status_d = STAT_MISS;
                state_d  = S_RESP;
              end
            end
            default: begin
              status_d = STAT_DONE;
              state_d  = S_RESP;
            end
          endcase
        end
      end

      S_FIX: begin
        // second lap: last entry moves into the removed slot
        ring_o.shift  = 1'b1;
        ring_o.entry  = last_q;
        ring_o.inject = idx_q == pos_q;
        idx_d         = idx_q + IdxW'(1);
        if (idx_q == LastIdx) begin
          idx_d    = '0;
          count_d  = count_q - CntW'(1);
          status_d = STAT_DONE;
          state_d  = S_RESP;
        end
      end

      S_RESP: begin
        done_o  = 1'b1;
        state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      idx_q   <= '0;
      hits_q  <= '0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      hits_q  <= hits_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cap_q    <= cap_d;
    pos_q    <= pos_d;
    kind_q   <= kind_d;
    status_q <= status_d;
    key_q    <= key_d;
    val_q    <= val_d;
    first_q  <= first_d;
    second_q <= second_d;
    last_q   <= last_d;
  end

  assign rsp_o = '{
    status:       status_q,
    first_value:  first_q,
    second_value: second_q,
    pair_count:   5'(count_q),
    is_empty:     count_q == '0,
    is_full:      count_q >= cap_q
  };

  // the result strobe always ends busy
  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy)
    else $error("busy still high after result strobe");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("pair count above depth");

  a_lap_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP || state_q == S_IDLE) |-> idx_q == '0)
    else $error("ring left out of alignment after a lap");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIND && kind_q == KIND_SEARCH) |=> $stable(count_q))
    else $error("search changed the pair count");

endmodule

FILE: sv/two_value_key_table_unit.sv
// ----------------------------------------------------------------------------
// two_value_key_table_unit: key/value table with at most two values per key
// Fixed-capacity pair table on a rotating ring of entry cells, with add,
// search and exact-pair remove.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive req_i and raise start; the transaction is taken
//   at a rising edge with start high and busy low. busy stays high until
//   the result has been shown.
//   Result channel: done_o is high for exactly one cycle with rsp_o valid.
//   The receiver cannot stall; it must take the result in that cycle.
//   Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
//   (0 capacity in use, 1 null marker) in the same edge; write only while
//   busy is low.
//   Operation: the entries sit in a ring of Depth cells that rotates one
//   slot per cycle during a scan and holds otherwise; the head cell is
//   compared against the command. A scan is one full lap. A successful
//   remove needs a second lap to move the last pair into the freed slot.
//   An add on a full table and the unused operation code skip the scan.
//   Reset: pair count cleared, capacity 16, null marker 0; the entry cells
//   are not cleared, since only slots below the pair count are ever read.
// ----------------------------------------------------------------------------
module two_value_key_table_unit
  import tvkt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  tvkt_req_t        req_i,
  output logic             done_o,
  output tvkt_rsp_t        rsp_o,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [DataW-1:0] cfg_wdata_i
);

  ring_ctl_t ring_ctl;
  entry_t    ring [Depth];

  tvkt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .head_i      (ring[0]),
    .ring_o      (ring_ctl)
  );

  // Cell i takes from cell i+1; the tail takes from the head, so the head
  // sees table entries in order and the tail is the write point: whatever
  // the tail loads while the head holds entry k becomes entry k after a lap.
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    ring_ctl_t cell_ctl;

    always_comb begin
      cell_ctl        = ring_ctl;
      cell_ctl.inject = ring_ctl.inject && (i == Depth - 1);
    end

    tvkt_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (cell_ctl),
      .nbr_i   (ring[(i + 1) % Depth]),
      .entry_o (ring[i])
    );
  end

endmodule

FILE: dv/two_value_key_table_unit_tb.sv
// ----------------------------------------------------------------------------
// two_value_key_table_unit_tb: self-checking bench of the two-value key table
// A short table of directed commands walks the corner cases. Random phases
// follow, each with its own capacity and null marker. A shadow copy of the
// table predicts every result, and each result is checked field by field.
// ----------------------------------------------------------------------------
module two_value_key_table_unit_tb;
  import tvkt_pkg::*;

  localparam int          Phases     = 8;
  localparam int          PerPhase   = 72;
  localparam int          IdlePct    = 22;
  localparam int          QuietPhase = 2;   // phase driven back to back
  localparam int          DirRows    = 29;
  localparam int          KeyPool    = 10;
  localparam int          ValPool    = 4;
  localparam logic [31:0] KeyMin     = 32'h8000_0000;
  localparam logic [31:0] KeyMax     = 32'h7fff_ffff;
  localparam logic [31:0] AllOnes    = 32'hffff_ffff;
  localparam logic [31:0] NullMark   = 32'hdead_beef;

  // one line of the directed plan: a register write or a command
  typedef struct packed {
    logic             is_cfg;
    reg_e             reg_sel;
    logic [DataW-1:0] wdata;
    tvkt_req_t        req;
    logic             typed;   // rsp holds a hand-written expectation
    tvkt_rsp_t        rsp;
  } plan_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             start;
  logic             busy;
  tvkt_req_t        req_i;
  logic             done_o;
  tvkt_rsp_t        rsp_o;
  logic             cfg_we_i;
  logic             cfg_idx_i;
  logic [DataW-1:0] cfg_wdata_i;

  // shadow of the table contents and registers
  logic [DataW-1:0] shadow_key [Depth];
  logic [DataW-1:0] shadow_val [Depth];
  int unsigned      shadow_pairs;
  logic [CapW-1:0]  shadow_cap;
  logic [DataW-1:0] shadow_null;

  tvkt_rsp_t        rsp_queue [$];
  int unsigned      fail_cnt;
  int unsigned      cmd_cnt;
  int unsigned      reg_cnt;
  int unsigned      peak_pairs;
  int unsigned      status_cnt [3];
  logic             idle_en;
  int unsigned      add_hi;
  logic [DataW-1:0] key_pool [KeyPool];
  logic [DataW-1:0] val_pool [ValPool];
  plan_row_t        directed [DirRows];

  two_value_key_table_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .done_o     (done_o),
    .rsp_o      (rsp_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  // capacity as the table sees it: 0 reads as 1, anything above Depth as Depth
  function automatic int unsigned table_limit();
    if (shadow_cap == '0) return 1;
    if (32'(shadow_cap) > Depth) return Depth;
    return 32'(shadow_cap);
  endfunction

  // applies one command to the shadow table and returns its result
  function automatic tvkt_rsp_t table_apply(input tvkt_req_t cmd);
    tvkt_rsp_t   res;
    int unsigned lim;
    int unsigned hits;
    int unsigned slot;
    lim              = table_limit();
    hits             = 0;
    slot             = shadow_pairs;
    res.status       = STAT_MISS;
    res.first_value  = shadow_null;
    res.second_value = shadow_null;
    case (cmd.kind)
      KIND_ADD: begin
        // full is tested before the per-key limit
        if (shadow_pairs >= lim) begin
          res.status = STAT_FULL;
        end else begin
          for (int i = 0; i < shadow_pairs; i++)
            if (shadow_key[i] == cmd.key) hits++;
          if (hits < MaxPerKey) begin
            shadow_key[shadow_pairs] = cmd.key;
            shadow_val[shadow_pairs] = cmd.value;
            shadow_pairs++;
            res.status = STAT_DONE;
          end
        end
      end
      KIND_SEARCH: begin
        for (int i = 0; i < shadow_pairs; i++) begin
          if (shadow_key[i] == cmd.key && hits < MaxPerKey) begin
            if (hits == 0) res.first_value = shadow_val[i];
            else res.second_value = shadow_val[i];
            hits++;
          end
        end
        res.status = STAT_DONE;
      end
      KIND_REMOVE: begin
        for (int i = shadow_pairs - 1; i >= 0; i--)
          if (shadow_key[i] == cmd.key && shadow_val[i] == cmd.value) slot = i;
        if (slot < shadow_pairs) begin
          // last pair fills the hole
          shadow_key[slot] = shadow_key[shadow_pairs - 1];
          shadow_val[slot] = shadow_val[shadow_pairs - 1];
          shadow_pairs--;
          res.status = STAT_DONE;
        end
      end
      default: ;
    endcase
    res.pair_count = 5'(shadow_pairs);
    res.is_empty   = (shadow_pairs == 0);
    res.is_full    = (shadow_pairs >= lim);
    status_cnt[res.status]++;
    if (shadow_pairs > peak_pairs) peak_pairs = shadow_pairs;
    return res;
  endfunction

  function automatic plan_row_t row_cmd(input kind_e kind, input logic [31:0] key,
                                        input logic [31:0] value);
    plan_row_t row;
    row           = '0;
    row.req.kind  = kind;
    row.req.key   = key;
    row.req.value = value;
    return row;
  endfunction

  function automatic plan_row_t row_chk(input kind_e kind, input logic [31:0] key,
                                        input logic [31:0] value, input status_e st,
                                        input logic [31:0] first, input logic [31:0] second,
                                        input int unsigned pairs, input logic empty,
                                        input logic full);
    plan_row_t row;
    row                  = row_cmd(kind, key, value);
    row.typed            = 1'b1;
    row.rsp.status       = st;
    row.rsp.first_value  = first;
    row.rsp.second_value = second;
    row.rsp.pair_count   = 5'(pairs);
    row.rsp.is_empty     = empty;
    row.rsp.is_full      = full;
    return row;
  endfunction

  function automatic plan_row_t row_reg(input reg_e sel, input logic [31:0] data);
    plan_row_t row;
    row         = '0;
    row.is_cfg  = 1'b1;
    row.reg_sel = sel;
    row.wdata   = data;
    return row;
  endfunction

  // one command transaction; the expectation is queued at the accepting edge
  task automatic send_cmd(input tvkt_req_t cmd, input logic typed,
                          input tvkt_rsp_t typed_rsp);
    tvkt_rsp_t predicted;
    cfg_we_i <= 1'b0;
    while (idle_en && $urandom_range(99) < IdlePct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= cmd;
    do begin
      @(posedge clk_i);
    end while (busy);
    predicted = table_apply(cmd);
    rsp_queue.push_back(typed ? typed_rsp : predicted);
    cmd_cnt++;
  endtask

  // register write, only once the table has gone quiet
  task automatic write_reg(input reg_e sel, input logic [DataW-1:0] data);
    start <= 1'b0;
    while (rsp_queue.size() != 0 || busy) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= sel;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    if (sel == REG_CAPACITY) shadow_cap = data[CapW-1:0];
    else shadow_null = data;
    reg_cnt++;
  endtask

  // random command: mostly pool keys so that pairs, duplicates and removes meet
  function automatic tvkt_req_t pick_cmd();
    tvkt_req_t   cmd;
    int unsigned roll;
    int unsigned slot;
    roll      = $urandom_range(99);
    cmd.kind  = KIND_SEARCH;
    cmd.key   = key_pool[$urandom_range(KeyPool - 1)];
    cmd.value = val_pool[$urandom_range(ValPool - 1)];
    if (roll < 6) begin
      cmd.kind  = 2'($urandom);
      cmd.key   = $urandom;
      cmd.value = $urandom;
    end else if (roll < 9) begin
      cmd.kind = KIND_NONE;
    end else if (roll < 33 && shadow_pairs > 0) begin
      slot      = $urandom_range(shadow_pairs - 1);
      cmd.kind  = KIND_REMOVE;
      cmd.key   = shadow_key[slot];
      cmd.value = shadow_val[slot];
    end else if (roll < 40) begin
      cmd.kind = KIND_REMOVE;
    end else if (roll < add_hi) begin
      cmd.kind = KIND_ADD;
    end
    return cmd;
  endfunction

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
      fail_cnt++;
    end
  endfunction

  // result side: done_o cannot be held off, so every strobe is taken
  always @(posedge clk_i) begin
    tvkt_rsp_t want;
    if (rst_ni && done_o) begin
      if (rsp_queue.size() == 0) begin
        $display("%0t: result with nothing pending, actual %h", $time, rsp_o);
        fail_cnt++;
      end else begin
        want = rsp_queue.pop_front();
        check_field("status", 32'(want.status), 32'(rsp_o.status));
        check_field("first_value", want.first_value, rsp_o.first_value);
        check_field("second_value", want.second_value, rsp_o.second_value);
        check_field("pair_count", 32'(want.pair_count), 32'(rsp_o.pair_count));
        check_field("is_empty", 32'(want.is_empty), 32'(rsp_o.is_empty));
        check_field("is_full", 32'(want.is_full), 32'(rsp_o.is_full));
      end
    end
  end

  initial begin
    logic [CapW-1:0]  cap_pick;
    logic [DataW-1:0] null_pick;
    rst_ni       <= 1'b0;
    start        <= 1'b0;
    req_i        <= '0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= REG_CAPACITY;
    cfg_wdata_i  <= '0;
    idle_en      = 1'b1;
    add_hi       = 78;
    shadow_pairs = 0;
    shadow_cap   = CapW'(CapReset);
    shadow_null  = '0;
    fail_cnt     = 0;
    cmd_cnt      = 0;
    reg_cnt      = 0;
    peak_pairs   = 0;
    status_cnt   = '{0, 0, 0};

    directed = '{
      // empty table right after reset
      row_chk(KIND_SEARCH, 32'd0, 32'd0, STAT_DONE, 32'd0, 32'd0, 0, 1'b1, 1'b0),
      row_chk(KIND_REMOVE, 32'd0, 32'd0, STAT_MISS, 32'd0, 32'd0, 0, 1'b1, 1'b0),
      row_chk(KIND_NONE, KeyMax, KeyMin, STAT_MISS, 32'd0, 32'd0, 0, 1'b1, 1'b0),
      // two values per key, the third is refused
      row_chk(KIND_ADD, KeyMin, KeyMax, STAT_DONE, 32'd0, 32'd0, 1, 1'b0, 1'b0),
      row_chk(KIND_ADD, KeyMin, 32'd0, STAT_DONE, 32'd0, 32'd0, 2, 1'b0, 1'b0),
      row_chk(KIND_ADD, KeyMin, AllOnes, STAT_MISS, 32'd0, 32'd0, 2, 1'b0, 1'b0),
      row_cmd(KIND_SEARCH, KeyMin, AllOnes),
      row_cmd(KIND_ADD, KeyMax, KeyMin),
      row_cmd(KIND_ADD, AllOnes, AllOnes),
      row_cmd(KIND_SEARCH, AllOnes, 32'd0),
      // remove the head pair (last pair moves in), an absent pair, the tail pair
      row_cmd(KIND_REMOVE, KeyMin, KeyMax),
      row_cmd(KIND_REMOVE, KeyMin, 32'd5),
      row_cmd(KIND_SEARCH, KeyMin, 32'd0),
      row_cmd(KIND_REMOVE, KeyMax, KeyMin),
      row_reg(REG_NULL, NullMark),
      row_cmd(KIND_ADD, KeyMin, 32'd7),
      // capacity 0 acts as 1, already below the count: full wins over duplicate
      row_reg(REG_CAPACITY, 32'd0),
      row_chk(KIND_ADD, KeyMin, 32'd1, STAT_FULL, NullMark, NullMark, 3, 1'b0, 1'b1),
      row_chk(KIND_SEARCH, 32'h1234_5678, 32'd0, STAT_DONE, NullMark, NullMark, 3,
              1'b0, 1'b1),
      row_chk(KIND_NONE, 32'd0, 32'd0, STAT_MISS, NullMark, NullMark, 3, 1'b0, 1'b1),
      // oversized capacity clamps to the depth
      row_reg(REG_CAPACITY, AllOnes),
      row_cmd(KIND_ADD, 32'd5, 32'd5),
      row_reg(REG_CAPACITY, 32'd5),
      row_cmd(KIND_ADD, 32'd6, 32'd6),
      row_chk(KIND_ADD, 32'd9, 32'd9, STAT_FULL, NullMark, NullMark, 5, 1'b0, 1'b1),
      row_cmd(KIND_SEARCH, KeyMin, 32'd0),
      row_cmd(KIND_REMOVE, AllOnes, AllOnes),
      row_cmd(KIND_REMOVE, 32'd5, 32'd5),
      row_reg(REG_CAPACITY, 32'd16)
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i]) begin
      if (directed[i].is_cfg) write_reg(directed[i].reg_sel, directed[i].wdata);
      else send_cmd(directed[i].req, directed[i].typed, directed[i].rsp);
    end

    for (int p = 0; p < Phases; p++) begin
      case (p)
        0:       cap_pick = 5'd16;
        1:       cap_pick = 5'd1;
        2:       cap_pick = 5'd0;
        3:       cap_pick = 5'd31;
        default: cap_pick = 5'($urandom_range(31));
      endcase
      null_pick = (p == 0) ? KeyMin : (p == 1) ? KeyMax : $urandom;
      // upper data bits are don't-care for the capacity register
      write_reg(REG_CAPACITY, ($urandom & ~32'h1f) | 32'(cap_pick));
      write_reg(REG_NULL, null_pick);

      key_pool = '{KeyMin, KeyMax, 32'd0, AllOnes, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom};
      val_pool = '{32'd0, $urandom, $urandom, (p % 2 == 0) ? KeyMin : KeyMax};
      idle_en  = (p != QuietPhase);
      add_hi   = (p % 2 == 1) ? 90 : 78;   // odd phases push toward full

      for (int n = 0; n < PerPhase; n++) send_cmd(pick_cmd(), 1'b0, '0);
    end

    start    <= 1'b0;
    cfg_we_i <= 1'b0;
    while (rsp_queue.size() != 0) @(posedge clk_i);
    repeat (2 * Depth + 4) @(posedge clk_i);

    $display("covered %0d commands: %0d done, %0d refused or absent, %0d on a full table",
             cmd_cnt, status_cnt[STAT_DONE], status_cnt[STAT_MISS], status_cnt[STAT_FULL]);
    $display("%0d register writes over %0d random phases, up to %0d pairs held",
             reg_cnt, Phases, peak_pairs);
    if (fail_cnt == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("timeout, %0d results still pending", rsp_queue.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: filelist.f
sv/tvkt_pkg.sv
sv/tvkt_cell.sv
sv/tvkt_ctrl.sv
sv/two_value_key_table_unit.sv
dv/two_value_key_table_unit_tb.sv
